### design/tcw_pkg.sv
// shared constants, types and command codes of the text console writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int DATA_W = 16;

    // character and cell codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'd13;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [DATA_W-1:0] RESET_BLANK  = 16'h0720;

    // opcodes of an input word
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [1:0] t_kind;
    localparam t_kind CMD_READ      = 2'd0;
    localparam t_kind CMD_READ_ZERO = 2'd1;
    localparam t_kind CMD_WRITE     = 2'd2;
    localparam t_kind CMD_MOVE      = 2'd3;

    // classified command passed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               scroll;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [DATA_W-1:0]  cell_data;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
        logic               scrolled;
    } t_rsp;

endpackage

### design/tcw_req_if.sv
// request channel of the text console writer
interface tcw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::IDX_W-1:0]     cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input cell_index,
                    output ready);
endinterface

### design/tcw_rsp_if.sv
// response channel of the text console writer
interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::DATA_W-1:0]    cell_data;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic                          scrolled;

    modport source (output valid, output cell_data, output cursor_row, output cursor_col,
                    output scrolled, input ready);
    modport sink   (input valid, input cell_data, input cursor_row, input cursor_col,
                    input scrolled, output ready);
endinterface

### design/text_console_writer_top.sv
// top level of the text console writer
//
// Teletype console over a 25 x 80 store of 16-bit cells (attribute, char).
// i_req carries one word per item: opcode put or read, char_code, cell_index.
// o_rsp returns one word per item: cell_data, cursor_row, cursor_col, scrolled.
// i_cfg_we / i_cfg_wdata write the text attribute used for new and blank cells.
// A put without scroll, a control byte or an out-of-range read is answered from the
// back end's output register; an in-range read also passes the store's read register.
// A scroll copies every row up one row, then blanks the bottom row, before its result.
// The back end takes no new command during a read, a scroll or while a result waits.
// After reset the back end sweeps the store to blank gray, one cell a cycle
// (all 2000 cells); i_req.ready is low during that sweep.
// A two-word command queue separates the front (cursor tracking) from the back
// (store access); the front keeps accepting while the back works or a result
// waits, until the queue fills. A stalled o_rsp holds its word.
module text_console_writer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tcw_req_if.sink                       i_req,
    tcw_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cfg_wdata
);

    logic [tcw_pkg::CHAR_W-1:0] r_attr;
    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       cmd_valid;
    logic                       clearing;
    tcw_pkg::t_cmd              front_cmd;
    tcw_pkg::t_cmd              back_cmd;

    // text attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // front end
    tcw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_attr  (r_attr),
        .i_hold  (clearing),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // command queue
    tcw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd)
    );

    // back end
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (pop),
        .o_clearing  (clearing),
        .o_rsp       (o_rsp)
    );

endmodule

### design/tcw_front.sv
// front end: accepts request words, tracks the cursor and classifies commands
module tcw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tcw_req_if.sink                       i_req,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_attr,
    input  logic                          i_hold,
    input  logic                          i_full,
    output logic                          o_push,
    output tcw_pkg::t_cmd                 o_cmd
);

    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [tcw_pkg::COL_W-1:0] r_col, n_col;
    logic                      at_last_row;
    logic                      at_last_col;
    logic [tcw_pkg::ROW_W-1:0] row_adv;
    logic [tcw_pkg::ADDR_W-1:0] put_addr;
    logic                      accept;

    // handshake
    assign i_req.ready = !i_full && !i_hold;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept;

    // row advance with scroll at the bottom line
    assign at_last_row = (r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign at_last_col = (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign row_adv     = at_last_row ? r_row : r_row + 1'b1;
    assign put_addr    = tcw_pkg::ADDR_W'(r_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                       + tcw_pkg::ADDR_W'(r_col);

    // classify the word and compute the next cursor
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        o_cmd.kind   = tcw_pkg::CMD_MOVE;
        o_cmd.addr   = put_addr;
        o_cmd.data   = {i_attr, i_req.char_code};
        o_cmd.scroll = 1'b0;
        if (i_req.opcode == tcw_pkg::OP_READ) begin
            o_cmd.addr = tcw_pkg::ADDR_W'(i_req.cell_index);
            if (32'(i_req.cell_index) < 32'(tcw_pkg::CELLS)) begin
                o_cmd.kind = tcw_pkg::CMD_READ;
            end else begin
                o_cmd.kind = tcw_pkg::CMD_READ_ZERO;
            end
        end else if (i_req.char_code == tcw_pkg::NEWLINE_CODE) begin
            n_col        = '0;
            n_row        = row_adv;
            o_cmd.scroll = at_last_row;
        end else if (i_req.char_code == tcw_pkg::RETURN_CODE) begin
            n_col = '0;
        end else begin
            o_cmd.kind = tcw_pkg::CMD_WRITE;
            if (at_last_col) begin
                n_col        = '0;
                n_row        = row_adv;
                o_cmd.scroll = at_last_row;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        o_cmd.row = n_row;
        o_cmd.col = n_col;
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

### design/tcw_cmd_fifo.sv
// two-entry command queue between front and back
module tcw_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcw_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tcw_pkg::t_cmd  o_cmd
);

    tcw_pkg::t_cmd                   r_entry [tcw_pkg::FIFO_DEPTH];
    logic [tcw_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [tcw_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [tcw_pkg::FIFO_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == tcw_pkg::FIFO_CNT_W'(tcw_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### design/tcw_back.sv
// back end: owns the cell store, runs writes, reads, scrolls and the reset clear
module tcw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tcw_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    tcw_rsp_if.source      o_rsp
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_COPY   = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_COPY =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);

    logic [2:0]                   r_state, n_state;
    logic [tcw_pkg::ADDR_W-1:0]   r_cnt, n_cnt;
    tcw_pkg::t_cmd                r_cmd;
    logic                         r_out_valid, n_out_valid;
    tcw_pkg::t_rsp                r_out, n_out;
    logic                         out_free;

    logic [tcw_pkg::DATA_W-1:0]   r_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::DATA_W-1:0]   r_rdata;
    logic                         mem_we;
    logic [tcw_pkg::ADDR_W-1:0]   mem_waddr;
    logic [tcw_pkg::DATA_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [tcw_pkg::ADDR_W-1:0]   mem_raddr;

    assign out_free   = !r_out_valid || o_rsp.ready;
    assign o_clearing = (r_state == S_CLEAR);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = tcw_pkg::RESET_BLANK;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        tcw_pkg::CMD_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = i_cmd.addr;
                            n_state   = S_RDWAIT;
                        end
                        tcw_pkg::CMD_READ_ZERO: begin
                            n_out_valid = 1'b1;
                            n_out       = '{'0, i_cmd.row, i_cmd.col, 1'b0};
                        end
                        tcw_pkg::CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_cmd.addr;
                            mem_wdata = i_cmd.data;
                        end
                        default: begin
                        end
                    endcase
                    if (i_cmd.kind == tcw_pkg::CMD_WRITE ||
                        i_cmd.kind == tcw_pkg::CMD_MOVE) begin
                        if (i_cmd.scroll) begin
                            n_cnt   = '0;
                            n_state = S_COPY;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out       = '{'0, i_cmd.row, i_cmd.col, 1'b0};
                        end
                    end
                end
            end
            S_RDWAIT: begin
                n_out_valid = 1'b1;
                n_out       = '{r_rdata, r_cmd.row, r_cmd.col, 1'b0};
                n_state     = S_IDLE;
            end
            S_COPY: begin
                // read one row ahead, write back the word read last cycle
                if (r_cnt != LAST_COPY) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cnt + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                end
                if (r_cnt != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt - 1'b1;
                    mem_wdata = r_rdata;
                end
                if (r_cnt == LAST_COPY) begin
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {r_cmd.data[tcw_pkg::DATA_W-1:tcw_pkg::CHAR_W],
                             tcw_pkg::SPACE_CHAR};
                if (r_cnt == LAST_CELL) begin
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{'0, r_cmd.row, r_cmd.col, 1'b1};
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // response word
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_data  = r_out.cell_data;
    assign o_rsp.cursor_row = r_out.cursor_row;
    assign o_rsp.cursor_col = r_out.cursor_col;
    assign o_rsp.scrolled   = r_out.scrolled;

`ifndef ASSERT_OFF
    // no result is pending while a scroll walks the store
    a_quiet_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY || r_state == S_BLANK) |-> !r_out_valid)
        else $error("result pending during scroll");

    // store writes stay inside the screen
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(tcw_pkg::CELLS)))
        else $error("store write out of range");

    // the reset clear ends after the last cell
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_cnt == LAST_CELL) |=> (r_state == S_IDLE))
        else $error("clear pass did not finish");

    // no command is taken while the clear runs
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd_pop)
        else $error("command taken during clear");
`endif

endmodule
